FILE: hdl/bmd_pkg.sv
package bmd_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int ITEM_BITS_DEF = 32;

	localparam int CMD_W    = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;

	localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_SEND_BACK  = 3'd0,
		CMD_SEND_FRONT = 3'd1,
		CMD_OVERWRITE  = 3'd2,
		CMD_RECEIVE    = 3'd3,
		CMD_PEEK       = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_FULL         = 2'd1,
		ST_EMPTY        = 2'd2,
		ST_NO_OVERWRITE = 2'd3
	} status_t;

	// per-request result handed from the control path to the output stage
	typedef struct packed {
		status_t           status;
		logic              rd_en;
		logic [LEN_W-1:0]  waiting;
		logic [LEN_W-1:0]  spaces;
	} resp_t;

endpackage

FILE: hdl/bmd_ram.sv
module bmd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/bmd_ctrl.sv
module bmd_ctrl #(
	parameter int DEPTH = bmd_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req,
	input  logic [bmd_pkg::CMD_W-1:0] cmd,
	input  logic                      cfg_we,
	input  logic [bmd_pkg::LEN_W-1:0] cfg_data,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_raddr,
	output bmd_pkg::resp_t            resp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > bmd_pkg::LEN_W) ? CW : bmd_pkg::LEN_W;

	logic [bmd_pkg::LEN_W-1:0] queue_length_q;
	logic [AW-1:0]             head_q;
	logic [CW-1:0]             count_q;

	logic [LW-1:0] len_wide;
	logic [CW-1:0] len;
	logic          full;
	logic          empty;
	logic [CW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_n;
	logic [CW-1:0] count_n;
	bmd_pkg::status_t status;

	always_comb begin
		len_wide = LW'(queue_length_q);
		if (len_wide == '0)
			len_wide = LW'(1);
		else if (len_wide > LW'(DEPTH))
			len_wide = LW'(DEPTH);
	end
	assign len = len_wide[CW-1:0];

	assign full  = (count_q >= len);
	assign empty = (count_q == '0);

	assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign tail     = (tail_sum >= (CW + 1)'(DEPTH)) ? AW'(tail_sum - (CW + 1)'(DEPTH))
		: AW'(tail_sum);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		head_n    = head_q;
		count_n   = count_q;
		status    = bmd_pkg::ST_OK;
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		unique case (cmd)
			bmd_pkg::CMD_SEND_BACK: begin
				if (full) begin
					status = bmd_pkg::ST_FULL;
				end else begin
					mem_we    = req;
					mem_waddr = tail;
					count_n   = count_q + CW'(1);
				end
			end
			bmd_pkg::CMD_SEND_FRONT: begin
				if (full) begin
					status = bmd_pkg::ST_FULL;
				end else begin
					mem_we    = req;
					mem_waddr = head_dec;
					head_n    = head_dec;
					count_n   = count_q + CW'(1);
				end
			end
			bmd_pkg::CMD_OVERWRITE: begin
				if (len != CW'(1)) begin
					status = bmd_pkg::ST_NO_OVERWRITE;
				end else begin
					mem_we = req;
					if (empty)
						count_n = CW'(1);
				end
			end
			bmd_pkg::CMD_RECEIVE: begin
				if (empty) begin
					status = bmd_pkg::ST_EMPTY;
				end else begin
					mem_re  = req;
					head_n  = head_inc;
					count_n = count_q - CW'(1);
				end
			end
			bmd_pkg::CMD_PEEK: begin
				if (empty)
					status = bmd_pkg::ST_EMPTY;
				else
					mem_re = req;
			end
			default: ;
		endcase
	end

	always_comb begin
		resp.status  = status;
		resp.rd_en   = mem_re;
		resp.waiting = bmd_pkg::LEN_W'(count_n);
		resp.spaces  = (count_n >= len) ? '0 : bmd_pkg::LEN_W'(len - count_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_length_q <= bmd_pkg::LEN_RESET;
			head_q         <= '0;
			count_q        <= '0;
		end else begin
			if (cfg_we)
				queue_length_q <= cfg_data;
			if (req) begin
				head_q  <= head_n;
				count_q <= count_n;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("item count above storage depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(DEPTH - 1))
		else $error("head slot out of range");

	a_receive_pops: assert property (@(posedge clk) disable iff (!arst_n)
		req && cmd == bmd_pkg::CMD_RECEIVE && !empty |=> count_q == $past(count_q) - CW'(1))
		else $error("receive did not remove one item");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		req && (cmd == bmd_pkg::CMD_SEND_BACK || cmd == bmd_pkg::CMD_SEND_FRONT) && full
		|=> $stable(count_q) && $stable(head_q))
		else $error("send to a full deque changed state");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("one request both writes and reads the store");

endmodule

FILE: hdl/bounded_message_deque_core.sv
// Bounded message deque core.
// Requests: drive cmd and item_data with start high; a request is taken at
// any rising edge where start is high and busy is low. busy stays low, so a
// new request may be issued every cycle.
// Commands: send back, send front, overwrite (only with length one),
// receive and peek. The result appears in the cycle after the request is
// taken, for exactly one cycle, marked by done: status, read_data (front
// item for a good receive or peek, else zero), waiting_count and
// spaces_left after the command.
// The result is registered, as is the read of the slot memory;
// throughput is one request per cycle, since head and count update at the
// request edge and the memory is written or read at that same edge.
// queue_length must be written through cfg_we/cfg_data only while no request
// is in flight (not enforced); 0 acts as 1, values above DEPTH act as DEPTH.
// Reset clears head, count and done and sets the length to 16; the result
// fields and slot contents are left as they are. The receiver cannot stall:
// each result must be taken in the cycle it is shown.
module bounded_message_deque_core #(
	parameter int DEPTH     = bmd_pkg::DEPTH_DEF,
	parameter int ITEM_BITS = bmd_pkg::ITEM_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bmd_pkg::CMD_W-1:0]    cmd,
	input  logic [bmd_pkg::DATA_W-1:0]   item_data,
	input  logic                         cfg_we,
	input  logic [bmd_pkg::LEN_W-1:0]    cfg_data,
	output logic                         done,
	output logic [bmd_pkg::STATUS_W-1:0] status,
	output logic [bmd_pkg::DATA_W-1:0]   read_data,
	output logic [bmd_pkg::LEN_W-1:0]    waiting_count,
	output logic [bmd_pkg::LEN_W-1:0]    spaces_left
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                 req;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [ITEM_BITS-1:0] mem_wdata;
	logic [ITEM_BITS-1:0] mem_rdata;
	logic [bmd_pkg::DATA_W-1:0] rdata_ext;
	bmd_pkg::resp_t       resp;
	bmd_pkg::resp_t       resp_s1;
	logic                 valid_s1;

	assign busy = 1'b0;
	assign req  = start && !busy;

	bmd_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.resp      (resp)
	);

	// items are kept to ITEM_BITS in the store
	generate
		if (ITEM_BITS >= bmd_pkg::DATA_W) begin : g_wide
			assign mem_wdata = ITEM_BITS'(item_data);
			assign rdata_ext = mem_rdata[bmd_pkg::DATA_W-1:0];
		end else begin : g_narrow
			assign mem_wdata = item_data[ITEM_BITS-1:0];
			assign rdata_ext = bmd_pkg::DATA_W'(mem_rdata);
		end
	endgenerate

	bmd_ram #(
		.WIDTH(ITEM_BITS),
		.DEPTH(DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (req)
			resp_s1 <= resp;
	end

	assign done          = valid_s1;
	assign status        = resp_s1.status;
	assign read_data     = resp_s1.rd_en ? rdata_ext : '0;
	assign waiting_count = resp_s1.waiting;
	assign spaces_left   = resp_s1.spaces;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req |=> done)
		else $error("request without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!req |=> !done)
		else $error("result without request");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != bmd_pkg::ST_OK |-> read_data == '0)
		else $error("refused request returned data");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bmd_pkg::*;

	localparam int LIMIT = 200000;
	localparam int IDX_W = $clog2(DEPTH_DEF);
	localparam int PHASES = 16;
	localparam int PHASE_REQS = 102;

	// command codes the block must treat as no-ops
	localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]  op;
		logic [DATA_W-1:0] data;
	} request_t;

	typedef struct {
		status_t           status;
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0]  waiting;
		logic [LEN_W-1:0]  spaces;
	} reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [CMD_W-1:0]    cmd = '0;
	logic [DATA_W-1:0]   item_data = '0;
	logic                cfg_we = 1'b0;
	logic [LEN_W-1:0]    cfg_data = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   read_data;
	logic [LEN_W-1:0]    waiting_count;
	logic [LEN_W-1:0]    spaces_left;

	bounded_message_deque_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.item_data     (item_data),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.read_data     (read_data),
		.waiting_count (waiting_count),
		.spaces_left   (spaces_left)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	request_t pending[$];
	reply_t   replies_due[$];

	// deque copy kept by the testbench
	logic [DATA_W-1:0] slot_copy [DEPTH_DEF];
	logic [IDX_W-1:0]  front_idx = '0;
	logic [LEN_W-1:0]  held = '0;
	logic [LEN_W-1:0]  length_reg = LEN_RESET;

	int  cycles = 0;
	int  requests_taken = 0;
	int  replies_checked = 0;
	int  length_writes = 0;
	int  mismatches = 0;
	int  status_seen [4] = '{0, 0, 0, 0};

	function automatic reply_t apply_deque_command(input logic [CMD_W-1:0] op,
			input logic [DATA_W-1:0] data);
		reply_t           r;
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] back_idx;
		// 0 behaves as 1, anything past the storage depth as the depth
		if (length_reg == '0)
			len = LEN_W'(1);
		else if (length_reg > LEN_W'(DEPTH_DEF))
			len = LEN_W'(DEPTH_DEF);
		else
			len = length_reg;
		back_idx = front_idx + IDX_W'(held);
		r.status = ST_OK;
		r.data = '0;
		case (op)
			CMD_SEND_BACK: begin
				if (held >= len) begin
					r.status = ST_FULL;
				end else begin
					slot_copy[back_idx] = data;
					held++;
				end
			end
			CMD_SEND_FRONT: begin
				if (held >= len) begin
					r.status = ST_FULL;
				end else begin
					front_idx--;
					slot_copy[front_idx] = data;
					held++;
				end
			end
			CMD_OVERWRITE: begin
				if (len != LEN_W'(1)) begin
					r.status = ST_NO_OVERWRITE;
				end else begin
					slot_copy[front_idx] = data;
					if (held == '0)
						held = LEN_W'(1);
				end
			end
			CMD_RECEIVE: begin
				if (held == '0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = slot_copy[front_idx];
					front_idx++;
					held--;
				end
			end
			CMD_PEEK: begin
				if (held == '0)
					r.status = ST_EMPTY;
				else
					r.data = slot_copy[front_idx];
			end
			default: ;
		endcase
		r.waiting = held;
		r.spaces = (held >= len) ? '0 : len - held;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// monitor: takes requests into the model and checks replies
	always @(posedge clk) begin : monitor
		reply_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, LIMIT);
			$display("bounded_message_deque_core test failed");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (replies_due.size() == 0) begin
					$display("%0t: reply with none outstanding, expected none, got status %0d data 0x%0h",
						$time, status, read_data);
					mismatches++;
				end else begin
					want = replies_due[0];
					replies_due.delete(0);
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("read_data", want.data, read_data);
					check_field("waiting_count", DATA_W'(want.waiting), DATA_W'(waiting_count));
					check_field("spaces_left", DATA_W'(want.spaces), DATA_W'(spaces_left));
					status_seen[want.status]++;
					replies_checked++;
				end
			end
			if (cfg_we) begin
				length_reg = cfg_data;
				length_writes++;
			end
			if (start && !busy) begin
				replies_due.insert(replies_due.size(), apply_deque_command(cmd, item_data));
				// the driver only raises start with the head of the pending queue
				pending.delete(0);
				requests_taken++;
			end
		end
	end

	// driver: one request per cycle at most, random gaps outside the calm window
	always @(negedge clk) begin : driver
		bit go;
		bit calm;
		calm = (requests_taken >= 700) && (requests_taken < 1000);
		go = arst_n && (pending.size() != 0) && (calm || $urandom_range(99) >= 13);
		start <= go;
		if (go) begin
			cmd <= pending[0].op;
			item_data <= pending[0].data;
		end else begin
			cmd <= CMD_W'($urandom);
			item_data <= $urandom;
		end
	end

	task automatic add_request(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] data);
		request_t q;
		q.op = op;
		q.data = data;
		pending.insert(pending.size(), q);
	endtask

	// length is only changed with nothing in flight
	task automatic set_length(input logic [LEN_W-1:0] v);
		while (pending.size() != 0 || replies_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int               ph;
		int               k;
		int               roll;
		int               fill;
		int               ow;
		logic [LEN_W-1:0] len;
		logic [CMD_W-1:0] op;
		logic [DATA_W-1:0] d;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// empty deque, refused overwrite, unknown commands, then sends, a peek and receives
		add_request(CMD_RECEIVE, $urandom);
		add_request(CMD_PEEK, $urandom);
		add_request(CMD_OVERWRITE, $urandom);
		for (k = CMD_BAD_FIRST; k <= CMD_BAD_LAST; k++)
			add_request(CMD_W'(k), $urandom);
		add_request(CMD_SEND_BACK, '0);
		add_request(CMD_SEND_FRONT, '1);
		add_request(CMD_PEEK, $urandom);
		add_request(CMD_RECEIVE, $urandom);
		add_request(CMD_RECEIVE, $urandom);

		// length one: overwrite on empty stores, then replaces the front
		set_length(LEN_W'(1));
		add_request(CMD_OVERWRITE, 32'ha5a5_a5a5);
		add_request(CMD_PEEK, $urandom);
		add_request(CMD_OVERWRITE, 32'h5a5a_5a5a);
		add_request(CMD_SEND_BACK, $urandom);
		add_request(CMD_SEND_FRONT, $urandom);
		add_request(CMD_RECEIVE, $urandom);
		add_request(CMD_RECEIVE, $urandom);

		set_length('0);
		add_request(CMD_OVERWRITE, $urandom);
		add_request(CMD_RECEIVE, $urandom);

		set_length('1);
		add_request(CMD_SEND_BACK, $urandom);
		add_request(CMD_OVERWRITE, $urandom);
		add_request(CMD_RECEIVE, $urandom);

		for (ph = 0; ph < PHASES; ph++) begin
			// a filling phase is followed by a short length, so the count
			// is left above the new length
			if (ph == 0)
				len = LEN_W'(DEPTH_DEF);
			else if (ph % 3 == 1)
				len = LEN_W'($urandom_range(3, 0));
			else if ($urandom_range(5) == 0)
				len = LEN_W'($urandom_range(31, 17));
			else
				len = LEN_W'($urandom_range(16, 1));
			set_length(len);
			fill = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 35 : 55;
			ow = (len <= LEN_W'(1)) ? 25 : 6;
			for (k = 0; k < PHASE_REQS; k++) begin
				roll = $urandom_range(99);
				if (roll < 3)
					op = CMD_W'($urandom_range(CMD_BAD_LAST, CMD_BAD_FIRST));
				else if (roll < 3 + ow)
					op = CMD_OVERWRITE;
				else if ($urandom_range(99) < fill)
					op = $urandom_range(1) ? CMD_SEND_BACK : CMD_SEND_FRONT;
				else
					op = ($urandom_range(3) == 0) ? CMD_PEEK : CMD_RECEIVE;
				case ($urandom_range(15))
					0: d = '0;
					1: d = '1;
					default: d = $urandom;
				endcase
				add_request(op, d);
			end
		end

		while (pending.size() != 0 || replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d requests over %0d length writes, %0d replies checked",
			requests_taken, length_writes, replies_checked);
		$display("replies by status: ok %0d, full %0d, empty %0d, overwrite refused %0d",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_NO_OVERWRITE]);
		if (mismatches == 0)
			$display("bounded_message_deque_core test passed");
		else
			$display("bounded_message_deque_core test failed");
		$finish;
	end

endmodule
